[rtl/hkbe_pkg.sv]
// Shared types, keycodes and decode helpers for the keyboard-report to button-edge block.
`default_nettype none

package hkbe_pkg;

  localparam int unsigned NBTN  = 4;
  localparam int unsigned NPASS = 6;
  localparam int unsigned NKEYS = 6;

  typedef logic [NBTN-1:0] btn_set_t;

  typedef enum logic [1:0] {
    KIND_REPORT   = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_SUPPRESS = 2'd2,
    KIND_DELIVERY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  localparam logic RES_REQUEST = 1'b0;
  localparam logic RES_EDGE    = 1'b1;

  // Button indices.
  localparam int unsigned BTN_BACK   = 0;
  localparam int unsigned BTN_UP     = 1;
  localparam int unsigned BTN_SELECT = 2;
  localparam int unsigned BTN_DOWN   = 3;

  // HID usage keycodes.
  localparam logic [7:0] KEY_UP        = 8'h52;
  localparam logic [7:0] KEY_DOWN      = 8'h51;
  localparam logic [7:0] KEY_ENTER     = 8'h28;
  localparam logic [7:0] KEY_RIGHT     = 8'h4f;
  localparam logic [7:0] KEY_ESCAPE    = 8'h29;
  localparam logic [7:0] KEY_LEFT      = 8'h50;
  localparam logic [7:0] KEY_BACKSPACE = 8'h2a;
  localparam logic [7:0] KEY_ERR_LO    = 8'h01;
  localparam logic [7:0] KEY_ERR_HI    = 8'h03;

  // Edge direction of each delivery pass, bit p for pass p: up, down,
  // re-press up, re-press down, tap down, tap up.
  localparam logic [NPASS-1:0] PASS_PRESSED = 6'b011010;

  typedef struct packed {
    logic load;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
    logic last_res;
  } dp_status_t;

  function automatic btn_set_t key_to_bits(input logic [7:0] k);
    btn_set_t b;
    b = '0;
    case (k)
      KEY_UP:                               b[BTN_UP]     = 1'b1;
      KEY_DOWN:                             b[BTN_DOWN]   = 1'b1;
      KEY_ENTER, KEY_RIGHT:                 b[BTN_SELECT] = 1'b1;
      KEY_ESCAPE, KEY_LEFT, KEY_BACKSPACE:  b[BTN_BACK]   = 1'b1;
      default:                              b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/hid_keys_to_button_edges.sv]
// Top level of the keyboard-report to button-edge converter.
`default_nettype none

// Turns keyboard reports into up and down edges for four buttons (back, up,
// select, down). Each request is one of four kinds: a report, a release of all
// keys, a suppression of Enter during pairing, or a delivery slot. Reports and
// releases update the target, seen and released button sets and produce a
// single delivery request result when a change appears and none is already
// pending. A delivery slot emits the pending button edges in a fixed order:
// releases, new presses, re-presses (up then down) and taps (down then up),
// each pass in ascending button order, with last set on the final one. A suppression
// request needs no sequencing phase; a report or
// release is accepted and then emits or discards its request result; a
// delivery is accepted and then emits its edges, and ends with no result when
// it has no edges. The edge sequencer writes one result per cycle into the
// output register while the output is not stalled; a stall holds the sequence.
// The input stalls while a request's results are being sequenced, but a new
// request is taken as soon as the last result has reached the output register.

module hid_keys_to_button_edges (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] kind_i,
  input  wire logic       report_ok_i,
  input  wire logic [7:0] reserved_byte_i,
  input  wire logic [7:0] key0_i,
  input  wire logic [7:0] key1_i,
  input  wire logic [7:0] key2_i,
  input  wire logic [7:0] key3_i,
  input  wire logic [7:0] key4_i,
  input  wire logic [7:0] key5_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            result_kind_o,
  output logic [1:0]      button_id_o,
  output logic            pressed_o,
  output logic            last_o
);

  hkbe_pkg::ctrl_cmd_t  cmd;
  hkbe_pkg::dp_status_t status;

  // Sequencing control and the output valid flag.
  hkbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Button state, pass masks and the result payload register.
  hkbe_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (kind_i),
    .report_ok_i     (report_ok_i),
    .reserved_byte_i (reserved_byte_i),
    .key0_i          (key0_i),
    .key1_i          (key1_i),
    .key2_i          (key2_i),
    .key3_i          (key3_i),
    .key4_i          (key4_i),
    .key5_i          (key5_i),
    .result_kind_o   (result_kind_o),
    .button_id_o     (button_id_o),
    .pressed_o       (pressed_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

[rtl/hkbe_ctrl.sv]
// Controller state machine: input acceptance, result sequencing and output valid.
`default_nettype none

module hkbe_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             kind_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output hkbe_pkg::ctrl_cmd_t         cmd_o,
  input  wire hkbe_pkg::dp_status_t   status_i
);

  hkbe_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign in_stall_o  = (state_q != hkbe_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.load = in_valid_i && (state_q == hkbe_pkg::ST_IDLE);
    cmd_o.push = (state_q == hkbe_pkg::ST_EMIT) && status_i.busy && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hkbe_pkg::ST_IDLE: begin
        if (cmd_o.load && (kind_i != hkbe_pkg::KIND_SUPPRESS)) begin
          state_d = hkbe_pkg::ST_EMIT;
        end
      end
      hkbe_pkg::ST_EMIT: begin
        if (!status_i.busy || (cmd_o.push && status_i.last_res)) begin
          state_d = hkbe_pkg::ST_IDLE;
        end
      end
      default: state_d = hkbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hkbe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result is only produced while sequencing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> state_q == hkbe_pkg::ST_EMIT)
    else $error("result pushed outside the emit state");

  // A held result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.push)
    else $error("output register overwritten while stalled");

  // Any request other than suppression starts a sequencing phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && kind_i != hkbe_pkg::KIND_SUPPRESS) |=> state_q == hkbe_pkg::ST_EMIT)
    else $error("accepted request did not start sequencing");

  // The final result of a request returns the controller to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push && status_i.last_res) |=> state_q == hkbe_pkg::ST_IDLE)
    else $error("controller stayed busy after the final result");

endmodule

`default_nettype wire

[rtl/hkbe_dp.sv]
// Datapath: report decode, button set state, delivery pass masks and output payload.
`default_nettype none

module hkbe_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hkbe_pkg::ctrl_cmd_t    cmd_i,
  output hkbe_pkg::dp_status_t        status_o,
  input  wire logic [1:0]             kind_i,
  input  wire logic                   report_ok_i,
  input  wire logic [7:0]             reserved_byte_i,
  input  wire logic [7:0]             key0_i,
  input  wire logic [7:0]             key1_i,
  input  wire logic [7:0]             key2_i,
  input  wire logic [7:0]             key3_i,
  input  wire logic [7:0]             key4_i,
  input  wire logic [7:0]             key5_i,
  output logic                        result_kind_o,
  output logic [1:0]                  button_id_o,
  output logic                        pressed_o,
  output logic                        last_o
);

  localparam int unsigned PW = $clog2(hkbe_pkg::NPASS);
  localparam int unsigned BW = $clog2(hkbe_pkg::NBTN);

  hkbe_pkg::btn_set_t target_q, target_d;
  hkbe_pkg::btn_set_t seen_q, seen_d;
  hkbe_pkg::btn_set_t released_q, released_d;
  hkbe_pkg::btn_set_t reported_q, reported_d;
  logic               pending_q, pending_d;
  logic               supp_q, supp_d;
  logic               req_q, req_d;
  hkbe_pkg::btn_set_t mask_q [hkbe_pkg::NPASS];
  hkbe_pkg::btn_set_t mask_d [hkbe_pkg::NPASS];

  logic                       res_kind_q;
  logic [BW-1:0]              res_btn_q;
  logic                       res_pressed_q;
  logic                       res_last_q;

  logic [7:0]         keys [hkbe_pkg::NKEYS];
  logic               key_err, has_enter, frame_ok, report_good;
  hkbe_pkg::btn_set_t rep_bits, new_bits, retaken, tapped;
  logic               changed, sched;

  logic               found, later_nz, cur_last;
  logic [PW-1:0]      sel_pass;
  logic [BW-1:0]      sel_btn;
  logic               btn_found;
  hkbe_pkg::btn_set_t sel_mask, clr_mask;

  assign keys[0] = key0_i;
  assign keys[1] = key1_i;
  assign keys[2] = key2_i;
  assign keys[3] = key3_i;
  assign keys[4] = key4_i;
  assign keys[5] = key5_i;

  // Report decode: Enter is dropped while suppression holds.
  always_comb begin
    key_err   = 1'b0;
    has_enter = 1'b0;
    rep_bits  = '0;
    for (int i = 0; i < hkbe_pkg::NKEYS; i++) begin
      if (keys[i] >= hkbe_pkg::KEY_ERR_LO && keys[i] <= hkbe_pkg::KEY_ERR_HI) begin
        key_err = 1'b1;
      end
      if (keys[i] == hkbe_pkg::KEY_ENTER) begin
        has_enter = 1'b1;
      end
      if (!(keys[i] == hkbe_pkg::KEY_ENTER && supp_q)) begin
        rep_bits = rep_bits | hkbe_pkg::key_to_bits(keys[i]);
      end
    end
  end

  assign frame_ok    = report_ok_i && (reserved_byte_i == 8'd0);
  assign report_good = frame_ok && !key_err;
  assign new_bits    = (kind_i == hkbe_pkg::KIND_REPORT && report_good) ? rep_bits : '0;
  assign changed     = (target_q != new_bits) || (seen_q != new_bits) || (released_q != '0);
  assign sched       = changed && !pending_q;
  assign retaken     = released_q & target_q & reported_q;
  assign tapped      = seen_q & ~target_q & ~reported_q;

  // Pick the first non-empty pass and its lowest button.
  always_comb begin
    found    = 1'b0;
    sel_pass = '0;
    for (int p = 0; p < hkbe_pkg::NPASS; p++) begin
      if (!found && mask_q[p] != '0) begin
        found    = 1'b1;
        sel_pass = PW'(p);
      end
    end
    sel_mask  = mask_q[sel_pass];
    btn_found = 1'b0;
    sel_btn   = '0;
    for (int b = 0; b < hkbe_pkg::NBTN; b++) begin
      if (!btn_found && sel_mask[b]) begin
        btn_found = 1'b1;
        sel_btn   = BW'(b);
      end
    end
    clr_mask = sel_mask & (sel_mask - hkbe_pkg::btn_set_t'(1));
    later_nz = 1'b0;
    for (int p = 0; p < hkbe_pkg::NPASS; p++) begin
      if (PW'(p) > sel_pass && mask_q[p] != '0) begin
        later_nz = 1'b1;
      end
    end
    cur_last = req_q || (clr_mask == '0 && !later_nz);
  end

  always_comb begin
    status_o.busy     = req_q || found;
    status_o.last_res = cur_last;
  end

  always_comb begin
    target_d   = target_q;
    seen_d     = seen_q;
    released_d = released_q;
    reported_d = reported_q;
    pending_d  = pending_q;
    supp_d     = supp_q;
    req_d      = req_q;
    mask_d     = mask_q;
    if (cmd_i.load) begin
      case (kind_i)
        hkbe_pkg::KIND_REPORT, hkbe_pkg::KIND_RELEASE: begin
          if (kind_i == hkbe_pkg::KIND_RELEASE) begin
            supp_d = 1'b0;
          end else if (report_good && !has_enter) begin
            supp_d = 1'b0;
          end
          released_d = released_q | (target_q & ~new_bits);
          target_d   = new_bits;
          seen_d     = seen_q | new_bits;
          if (sched) begin
            pending_d = 1'b1;
          end
          req_d = sched;
        end
        hkbe_pkg::KIND_SUPPRESS: begin
          supp_d = 1'b1;
        end
        default: begin
          pending_d  = 1'b0;
          seen_d     = target_q;
          released_d = '0;
          reported_d = target_q;
          mask_d[0]  = reported_q & ~target_q;
          mask_d[1]  = target_q & ~reported_q;
          mask_d[2]  = retaken;
          mask_d[3]  = retaken;
          mask_d[4]  = tapped;
          mask_d[5]  = tapped;
        end
      endcase
    end else if (cmd_i.push) begin
      if (req_q) begin
        req_d = 1'b0;
      end else begin
        for (int p = 0; p < hkbe_pkg::NPASS; p++) begin
          if (PW'(p) == sel_pass) begin
            mask_d[p] = clr_mask;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      seen_q     <= '0;
      released_q <= '0;
      reported_q <= '0;
      pending_q  <= 1'b0;
      supp_q     <= 1'b0;
      req_q      <= 1'b0;
      for (int p = 0; p < hkbe_pkg::NPASS; p++) begin
        mask_q[p] <= '0;
      end
    end else begin
      target_q   <= target_d;
      seen_q     <= seen_d;
      released_q <= released_d;
      reported_q <= reported_d;
      pending_q  <= pending_d;
      supp_q     <= supp_d;
      req_q      <= req_d;
      mask_q     <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      res_kind_q    <= req_q ? hkbe_pkg::RES_REQUEST : hkbe_pkg::RES_EDGE;
      res_btn_q     <= req_q ? '0 : sel_btn;
      res_pressed_q <= req_q ? 1'b0 : hkbe_pkg::PASS_PRESSED[sel_pass];
      res_last_q    <= cur_last;
    end
  end

  assign result_kind_o = res_kind_q;
  assign button_id_o   = res_btn_q;
  assign pressed_o     = res_pressed_q;
  assign last_o        = res_last_q;

endmodule

`default_nettype wire
